>>> src/blcu_pkg.sv
// Package for the block length-code unpacker.
// Holds length-code constants and the struct passed from the field extract unit.
// No dependencies.
package blcu_pkg;

    localparam int BUF_W  = 40;  // body bit buffer width
    localparam int HELD_W = 6;   // bits-held counter width
    localparam int LEN_W  = 5;   // field length, up to 31
    localparam int WORD_W = 32;
    localparam int CODE_W = 4;

    localparam logic [CODE_W-1:0] CODE_ZERO = 4'd0;
    localparam logic [CODE_W-1:0] CODE_RAW  = 4'd1;

    localparam logic [LEN_W-1:0] RAW_BITS = 5'd18;
    localparam logic [LEN_W-1:0] LEN_BIAS = 5'd16;

    typedef struct packed {
        logic              need_more;  // not enough body bits buffered
        logic [LEN_W-1:0]  len;        // bits consumed by this word
        logic [WORD_W-1:0] word;       // decoded word
    } ext_t;

endpackage

>>> src/blcu_extract.sv
// Shared field extract unit: one variable shift, mask and implied-one insert.
// Depends on blcu_pkg.
module blcu_extract (
    input  logic [blcu_pkg::BUF_W-1:0]  buf_bits,
    input  logic [blcu_pkg::HELD_W-1:0] held,
    input  logic [blcu_pkg::CODE_W-1:0] code,
    output blcu_pkg::ext_t              ext
);

    logic [blcu_pkg::LEN_W-1:0]  len;
    logic [blcu_pkg::HELD_W-1:0] sh;
    logic [blcu_pkg::BUF_W-1:0]  shifted;
    logic [blcu_pkg::WORD_W-1:0] mask;
    logic [blcu_pkg::WORD_W-1:0] implied;

    always_comb begin
        case (code)
            blcu_pkg::CODE_ZERO: len = '0;
            blcu_pkg::CODE_RAW:  len = blcu_pkg::RAW_BITS;
            default:             len = blcu_pkg::LEN_BIAS + blcu_pkg::LEN_W'(code);
        endcase
    end

    // sh is meaningless when need_more is set; result is then ignored
    assign sh      = held - {1'b0, len};
    assign shifted = buf_bits >> sh;
    assign mask    = ~({blcu_pkg::WORD_W{1'b1}} << len);
    assign implied = (code == blcu_pkg::CODE_ZERO || code == blcu_pkg::CODE_RAW)
                     ? '0 : (blcu_pkg::WORD_W'(1) << len);

    assign ext.need_more = (code != blcu_pkg::CODE_ZERO) && (held < {1'b0, len});
    assign ext.len       = len;
    assign ext.word      = (shifted[blcu_pkg::WORD_W-1:0] & mask) | implied;

endmodule

>>> src/block_length_code_unpacker.sv
// Top level of the block length-code unpacker.
// Depends on blcu_pkg and blcu_extract.
//
// Usage:
//   s_ channel carries the compressed byte stream, one byte per transaction.
//   Each block opens with (WORDS_PER_BLOCK+1)/2 header bytes of 4-bit length
//   codes (high nibble first), then MSB-first body bits. The m_ channel
//   carries one decoded 32-bit word per transaction; m_block_end marks the
//   last word of a block.
// Sequencing:
//   Header bytes are taken one per cycle. After the last header byte, the
//   first word needs one header memory read (ST_FETCH) and one decode
//   (ST_DEC) before it is registered. Each later word takes one decode,
//   plus one header memory read per header byte (every second word), once
//   bits are buffered; all decodes use the single shared extract unit
//   (one variable shift). A word whose field is not yet buffered takes in
//   body bytes one at a time, each followed by a decode retry. Zero-coded
//   words consume no body bits and come out with the stream held off.
// Reset:
//   aresetn (synchronous, active low) returns to header collection with an
//   empty bit buffer. Header memory is not cleared; it is always written
//   before it is read in a block.
// Back-pressure:
//   One output register. While it holds an unaccepted word the decoder
//   waits; a following word that lacks bits can still take in body bytes.
module block_length_code_unpacker #(
    parameter int WORDS_PER_BLOCK = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_stream_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_word,
    output logic        m_block_end
);

    localparam int HDR_BYTES = (WORDS_PER_BLOCK + 1) / 2;
    localparam int HA_W      = (HDR_BYTES > 1) ? $clog2(HDR_BYTES) : 1;
    localparam int WI_W      = $clog2(WORDS_PER_BLOCK);

    typedef enum logic [1:0] {
        ST_HDR,    // collecting header bytes
        ST_FETCH,  // header memory read in flight
        ST_DEC,    // decoding current word
        ST_BODY    // waiting for a body byte
    } state_t;

    state_t                        state_reg, state_next;
    logic [HA_W-1:0]               hdr_cnt_reg, hdr_cnt_next;
    logic [WI_W-1:0]               word_idx_reg, word_idx_next;
    logic [blcu_pkg::BUF_W-1:0]    buf_reg, buf_next;
    logic [blcu_pkg::HELD_W-1:0]   held_reg, held_next;
    logic                          m_valid_reg, m_valid_next;
    logic [31:0]                   m_word_reg, m_word_next;
    logic                          m_block_end_reg, m_block_end_next;

    // header code memory
    logic [7:0]      hdr_mem [HDR_BYTES];
    logic [7:0]      hdr_byte_reg;
    logic [HA_W-1:0] rd_addr;
    logic            hdr_wr;

    logic                      in_acc;
    logic                      out_free;
    logic                      last_word;
    logic [blcu_pkg::CODE_W-1:0] code;
    blcu_pkg::ext_t            ext;

    assign s_ready   = (state_reg == ST_HDR) || (state_reg == ST_BODY);
    assign in_acc    = s_valid && s_ready;
    assign hdr_wr    = in_acc && (state_reg == ST_HDR);
    assign rd_addr   = HA_W'(word_idx_reg >> 1);
    assign out_free  = !m_valid_reg || m_ready;
    assign last_word = (word_idx_reg == WI_W'(WORDS_PER_BLOCK - 1));
    assign code      = word_idx_reg[0] ? hdr_byte_reg[3:0] : hdr_byte_reg[7:4];

    always_ff @(posedge aclk) begin
        if (hdr_wr) begin
            hdr_mem[hdr_cnt_reg] <= s_stream_byte;
        end
        hdr_byte_reg <= hdr_mem[rd_addr];
    end

    blcu_extract u_extract (
        .buf_bits (buf_reg),
        .held     (held_reg),
        .code     (code),
        .ext      (ext)
    );

    always_comb begin
        state_next       = state_reg;
        hdr_cnt_next     = hdr_cnt_reg;
        word_idx_next    = word_idx_reg;
        buf_next         = buf_reg;
        held_next        = held_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_word_next      = m_word_reg;
        m_block_end_next = m_block_end_reg;

        case (state_reg)
            ST_HDR: begin
                if (in_acc) begin
                    if (hdr_cnt_reg == HA_W'(HDR_BYTES - 1)) begin
                        hdr_cnt_next = '0;
                        state_next   = ST_FETCH;
                    end else begin
                        hdr_cnt_next = hdr_cnt_reg + 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_DEC;
            end
            ST_DEC: begin
                if (ext.need_more) begin
                    state_next = ST_BODY;
                end else if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_word_next      = ext.word;
                    m_block_end_next = last_word;
                    held_next        = held_reg - {1'b0, ext.len};
                    if (last_word) begin
                        // leftover padding bits dropped
                        word_idx_next = '0;
                        held_next     = '0;
                        state_next    = ST_HDR;
                    end else begin
                        word_idx_next = word_idx_reg + 1'b1;
                        // odd word done: next code lives in the next header byte
                        state_next    = word_idx_reg[0] ? ST_FETCH : ST_DEC;
                    end
                end
            end
            ST_BODY: begin
                if (in_acc) begin
                    buf_next   = {buf_reg[blcu_pkg::BUF_W-9:0], s_stream_byte};
                    held_next  = held_reg + blcu_pkg::HELD_W'(8);
                    state_next = ST_DEC;
                end
            end
            default: begin
                state_next = ST_HDR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_HDR;
            hdr_cnt_reg  <= '0;
            word_idx_reg <= '0;
            held_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            word_idx_reg <= word_idx_next;
            held_reg     <= held_next;
            m_valid_reg  <= m_valid_next;
        end
        buf_reg         <= buf_next;
        m_word_reg      <= m_word_next;
        m_block_end_reg <= m_block_end_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_word      = m_word_reg;
    assign m_block_end = m_block_end_reg;

    // buffer never overflows: a byte is only pulled in while held < 31
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= blcu_pkg::HELD_W'(38))
        else $error("bit buffer count out of range");

    a_block_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEC && !ext.need_more && out_free && last_word)
        |=> (state_reg == ST_HDR && word_idx_reg == '0 && held_reg == '0))
        else $error("block end did not restart header collection");

    a_body_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && state_reg == ST_BODY)
        |=> (held_reg == $past(held_reg) + blcu_pkg::HELD_W'(8)))
        else $error("body byte not added to bit count");

    a_no_emit_in_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HDR && hdr_cnt_reg != '0) |-> !m_valid_next || m_valid_reg)
        else $error("word produced during header collection");

endmodule
